@@ rtl/hopf_pkg.sv @@
// Package for the Hopfield associative memory core.
// Shared widths, defaults, opcode and sequencer state types.
// No dependencies.
package hopf_pkg;

	localparam int NEURONS_DEF      = 64;
	localparam int MAX_PATTERNS_DEF = 255;

	localparam int PAT_W    = 64;  // pattern port width
	localparam int WGT_W    = 9;   // signed weight, |w| <= 255
	localparam int CNT_W    = 8;   // pattern count
	localparam int SWEEP_W  = 8;   // max_sweeps register
	localparam int GRP      = 8;   // lanes per partial sum
	localparam int PSUM_W   = 13;  // sum of GRP weights
	localparam int FIELD_W  = 16;  // full local field
	localparam int ACC_W    = 22;  // energy double sum
	localparam int ENERGY_W = 20;

	localparam logic [SWEEP_W-1:0] MAX_SWEEPS_RST = SWEEP_W'(10);

	typedef enum logic [1:0] {
		OP_STORE  = 2'd0,
		OP_RECALL = 2'd1,
		OP_ENERGY = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_SUM  = 5'b00100,
		S_UPD  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

endpackage

@@ rtl/hopf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hopf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/hopf_field.sv @@
// Local field of one neuron: registered partial sums over lane groups,
// then a final add. Depends on hopf_pkg.
module hopf_field import hopf_pkg::*; #(
	parameter int NEURONS = NEURONS_DEF
) (
	input  logic                        clk,
	input  logic [NEURONS*WGT_W-1:0]    row,
	input  logic [NEURONS-1:0]          spins,
	output logic signed [FIELD_W-1:0]   field
);

	localparam int NGRP = (NEURONS + GRP - 1) / GRP;

	logic signed [PSUM_W-1:0] psum_d  [NGRP];
	logic signed [PSUM_W-1:0] psum_s1 [NGRP];

	always_comb begin
		logic signed [WGT_W-1:0]  w;
		logic signed [PSUM_W-1:0] term;
		w    = '0;
		term = '0;
		for (int g = 0; g < NGRP; g++) begin
			psum_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < NEURONS) begin
					w    = signed'(row[(g*GRP+k)*WGT_W +: WGT_W]);
					term = PSUM_W'(w);
					psum_d[g] = spins[g*GRP+k] ? psum_d[g] + term : psum_d[g] - term;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		psum_s1 <= psum_d;
	end

	always_comb begin
		field = '0;
		for (int g = 0; g < NGRP; g++) begin
			field = field + FIELD_W'(psum_s1[g]);
		end
	end

endmodule

@@ rtl/hopf_rowupd.sv @@
// Store update of one weight row: adds s_i*s_j off the diagonal.
// Depends on hopf_pkg.
module hopf_rowupd import hopf_pkg::*; #(
	parameter int NEURONS = NEURONS_DEF
) (
	input  logic [NEURONS*WGT_W-1:0]   row_in,
	input  logic [NEURONS-1:0]         spins,
	input  logic [$clog2(NEURONS)-1:0] row_idx,
	output logic [NEURONS*WGT_W-1:0]   row_out
);

	localparam int IDX_W = $clog2(NEURONS);

	always_comb begin
		logic [WGT_W-1:0] w;
		logic             si;
		w  = '0;
		si = spins[row_idx];
		for (int j = 0; j < NEURONS; j++) begin
			w = row_in[j*WGT_W +: WGT_W];
			if (IDX_W'(j) != row_idx) begin
				w = (spins[j] == si) ? w + WGT_W'(1) : w - WGT_W'(1);
			end
			row_out[j*WGT_W +: WGT_W] = w;
		end
	end

endmodule

@@ rtl/hopfield_associative_memory_core.sv @@
// Hopfield associative memory core: bipolar patterns over NEURONS cells,
// weight rows held in one synchronous RAM (one row of NEURONS weights per
// address) and worked on one row at a time. Per row, store reads the row,
// adds the outer product and writes it back; energy reads the row, takes
// the partial sums, then the field and accumulates; recall takes the same
// steps but updates the neuron, sweep after sweep; clear or a refused
// store goes straight to the result. The per-row cost is set by the one
// RAM read port and the registered field adder between it and the neuron
// update. Rows carry a valid bit cleared at reset and by clear, so no
// clearing pass runs and the block takes items right after reset. Results
// sit in an output register; the next item is taken while a result waits.
// Depends on hopf_pkg, hopf_ram, hopf_field, hopf_rowupd.
module hopfield_associative_memory_core import hopf_pkg::*; #(
	parameter int NEURONS      = NEURONS_DEF,
	parameter int MAX_PATTERNS = MAX_PATTERNS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 opcode,
	input  logic [PAT_W-1:0]           pattern_bits,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [PAT_W-1:0]           result_pattern,
	output logic signed [ENERGY_W-1:0] energy_value,
	output logic [CNT_W-1:0]           stored_count,
	output logic                       status,
	input  logic                       cfg_we,
	input  logic [SWEEP_W-1:0]         cfg_wdata
);

	localparam int IDX_W = $clog2(NEURONS);
	localparam int ROW_W = NEURONS * WGT_W;
	localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(NEURONS - 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PATTERNS);

	state_t                    state_q;
	op_t                       op_q;
	logic [NEURONS-1:0]        s_q;
	logic [IDX_W-1:0]          row_q;
	logic [SWEEP_W-1:0]        sweep_q;
	logic                      chg_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      refused_q;
	logic [NEURONS-1:0]        vld_q;
	logic                      vld_s1;
	logic [SWEEP_W-1:0]        max_sweeps_q;

	logic                      out_valid_q;
	logic [PAT_W-1:0]          result_q;
	logic signed [ENERGY_W-1:0] energy_q;
	logic [CNT_W-1:0]          count_q;
	logic                      status_q;

	// RAM ports
	logic                      ram_we;
	logic                      ram_re;
	logic [ROW_W-1:0]          ram_rdata;
	logic [ROW_W-1:0]          row_eff;
	logic [ROW_W-1:0]          row_new;
	logic signed [FIELD_W-1:0] field;

	// next-neuron decision
	logic                      new_bit;
	logic                      chg_now;
	logic                      out_load;
	logic signed [ACC_W-1:0]   half_neg;

	assign ram_re  = (state_q == S_RD);
	assign ram_we  = (state_q == S_SUM) && (op_q == OP_STORE);
	// never-written rows read as zero
	assign row_eff = vld_s1 ? ram_rdata : '0;

	hopf_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NEURONS)
	) u_wram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_q),
		.wdata (row_new),
		.re    (ram_re),
		.raddr (row_q),
		.rdata (ram_rdata)
	);

	hopf_rowupd #(.NEURONS(NEURONS)) u_rowupd (
		.row_in  (row_eff),
		.spins   (s_q),
		.row_idx (row_q),
		.row_out (row_new)
	);

	hopf_field #(.NEURONS(NEURONS)) u_field (
		.clk   (clk),
		.row   (row_eff),
		.spins (s_q),
		.field (field)
	);

	// tie at zero goes to +1
	assign new_bit  = ~field[FIELD_W-1];
	assign chg_now  = chg_q | (new_bit != s_q[row_q]);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);
	// double sum is even, so the shift is exact
	assign half_neg = -(acc_q >>> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_sweeps_q <= MAX_SWEEPS_RST;
		end else if (cfg_we) begin
			max_sweeps_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_STORE;
			s_q       <= '0;
			row_q     <= '0;
			sweep_q   <= '0;
			chg_q     <= 1'b0;
			acc_q     <= '0;
			cnt_q     <= '0;
			refused_q <= 1'b0;
			vld_q     <= '0;
			vld_s1    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q      <= op_t'(opcode);
						s_q       <= pattern_bits[NEURONS-1:0];
						row_q     <= '0;
						sweep_q   <= '0;
						chg_q     <= 1'b0;
						acc_q     <= '0;
						refused_q <= 1'b0;
						case (op_t'(opcode))
							OP_STORE: begin
								if (cnt_q >= CNT_MAX) begin
									refused_q <= 1'b1;
									state_q   <= S_OUT;
								end else begin
									state_q <= S_RD;
								end
							end
							OP_RECALL: begin
								state_q <= (max_sweeps_q == '0) ? S_OUT : S_RD;
							end
							OP_ENERGY: state_q <= S_RD;
							OP_CLEAR: begin
								vld_q   <= '0;
								cnt_q   <= '0;
								state_q <= S_OUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_RD: begin
					vld_s1  <= vld_q[row_q];
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (op_q == OP_STORE) begin
						vld_q[row_q] <= 1'b1;
						if (row_q == LAST_ROW) begin
							cnt_q   <= cnt_q + CNT_W'(1);
							state_q <= S_OUT;
						end else begin
							row_q   <= row_q + IDX_W'(1);
							state_q <= S_RD;
						end
					end else begin
						// partial sums registered in the field unit
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (op_q == OP_RECALL) begin
						s_q[row_q] <= new_bit;
						if (row_q == LAST_ROW) begin
							if (!chg_now ||
							    ({1'b0, sweep_q} + 9'd1 == {1'b0, max_sweeps_q})) begin
								state_q <= S_OUT;
							end else begin
								sweep_q <= sweep_q + SWEEP_W'(1);
								chg_q   <= 1'b0;
								row_q   <= '0;
								state_q <= S_RD;
							end
						end else begin
							chg_q   <= chg_now;
							row_q   <= row_q + IDX_W'(1);
							state_q <= S_RD;
						end
					end else begin
						acc_q <= s_q[row_q] ? acc_q + ACC_W'(field) : acc_q - ACC_W'(field);
						if (row_q == LAST_ROW) begin
							state_q <= S_OUT;
						end else begin
							row_q   <= row_q + IDX_W'(1);
							state_q <= S_RD;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			result_q    <= '0;
			energy_q    <= '0;
			count_q     <= '0;
			status_q    <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			result_q    <= (op_q == OP_RECALL) ? PAT_W'(s_q) : '0;
			energy_q    <= (op_q == OP_ENERGY) ? half_neg[ENERGY_W-1:0] : '0;
			count_q     <= cnt_q;
			status_q    <= refused_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign result_pattern = result_q;
	assign energy_value   = energy_q;
	assign stored_count   = count_q;
	assign status         = status_q;

endmodule

@@ rtl/hopf_chk.sv @@
// Port-level checker for the Hopfield memory core, bound to the top level.
// Depends on hopf_pkg.
module hopf_chk import hopf_pkg::*; #(
	parameter int MAX_PATTERNS = MAX_PATTERNS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [PAT_W-1:0]           result_pattern,
	input logic signed [ENERGY_W-1:0] energy_value,
	input logic [CNT_W-1:0]           stored_count,
	input logic                       status
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_pattern) &&
		$stable(energy_value) && $stable(stored_count) && $stable(status))
		else $error("result changed while stalled");

	// a refusal only happens at a full memory
	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> stored_count == CNT_W'(MAX_PATTERNS) &&
		result_pattern == '0 && energy_value == '0)
		else $error("refusal below capacity");

	// recall and energy results never appear together
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_pattern == '0 || energy_value == '0)
		else $error("both result kinds set");

	// the block works on one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready held after accept");

endmodule

bind hopfield_associative_memory_core hopf_chk #(.MAX_PATTERNS(MAX_PATTERNS)) u_chk (.*);

@@ tb/hopf_checker.sv @@
// Checker for the Hopfield associative memory core: watches both channels,
// predicts every result from its own weight model and compares field by field.
// Depends on hopf_pkg.
`timescale 1ns / 100ps
module hopf_checker import hopf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [1:0]                 opcode,
	input  logic [PAT_W-1:0]           pattern_bits,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [PAT_W-1:0]           result_pattern,
	input  logic signed [ENERGY_W-1:0] energy_value,
	input  logic [CNT_W-1:0]           stored_count,
	input  logic                       status,
	input  logic                       cfg_we,
	input  logic [SWEEP_W-1:0]         cfg_wdata,
	output int                         fail_count,
	output int                         pending
);

	localparam int N = NEURONS_DEF;

	typedef struct packed {
		logic [PAT_W-1:0]           pat;
		logic signed [ENERGY_W-1:0] energy;
		logic [CNT_W-1:0]           count;
		logic                       refused;
	} hopf_result_t;

	int                 wmat [N][N];
	int unsigned        held;
	logic [SWEEP_W-1:0] sweep_limit;
	hopf_result_t       expected_q [$];

	assign pending = expected_q.size();

	function automatic int field_of(logic [PAT_W-1:0] s, int i);
		int h;
		h = 0;
		for (int j = 0; j < N; j++)
			h += s[j] ? wmat[i][j] : -wmat[i][j];
		return h;
	endfunction

	function automatic hopf_result_t apply_item(op_t op, logic [PAT_W-1:0] s);
		hopf_result_t r;
		bit           changed;
		int           sum;
		r = '0;
		case (op)
			OP_STORE: begin
				if (held >= MAX_PATTERNS_DEF) begin
					r.refused = 1'b1;
				end else begin
					for (int i = 0; i < N; i++)
						for (int j = 0; j < N; j++)
							if (i != j)
								wmat[i][j] += (s[i] == s[j]) ? 1 : -1;
					held++;
				end
			end
			OP_RECALL: begin
				// asynchronous sweeps: later cells see updated values
				for (int sw = 0; sw < sweep_limit; sw++) begin
					changed = 0;
					for (int i = 0; i < N; i++) begin
						logic nb;
						nb = (field_of(s, i) >= 0);
						if (nb != s[i]) begin
							s[i] = nb;
							changed = 1;
						end
					end
					if (!changed)
						break;
				end
				r.pat = s;
			end
			OP_ENERGY: begin
				sum = 0;
				for (int i = 0; i < N; i++)
					sum += s[i] ? field_of(s, i) : -field_of(s, i);
				r.energy = ENERGY_W'(-(sum / 2));
			end
			default: begin
				foreach (wmat[i, j])
					wmat[i][j] = 0;
				held = 0;
			end
		endcase
		r.count = CNT_W'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (wmat[i, j])
				wmat[i][j] = 0;
			held        = 0;
			sweep_limit = MAX_SWEEPS_RST;
			fail_count  = 0;
			expected_q.delete();
		end else begin
			hopf_result_t e;
			if (cfg_we)
				sweep_limit = cfg_wdata;
			if (in_valid && in_ready)
				expected_q.insert(expected_q.size(), apply_item(op_t'(opcode), pattern_bits));
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result pattern=%h", $time, result_pattern);
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					if (result_pattern !== e.pat) begin
						$display("%0t: result_pattern exp %h got %h", $time, e.pat,
							result_pattern);
						fail_count++;
					end
					if (energy_value !== e.energy) begin
						$display("%0t: energy_value exp %0d got %0d", $time, e.energy,
							energy_value);
						fail_count++;
					end
					if (stored_count !== e.count) begin
						$display("%0t: stored_count exp %0d got %0d", $time, e.count,
							stored_count);
						fail_count++;
					end
					if (status !== e.refused) begin
						$display("%0t: status exp %0b got %0b", $time, e.refused, status);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

@@ tb/tb_hopfield_associative_memory_core.sv @@
// Testbench top for the Hopfield associative memory core: clock, reset,
// directed and random stimulus, register phases and the verdict.
// Depends on hopf_pkg, hopf_checker and the core RTL.
`timescale 1ns / 100ps
module tb_hopfield_associative_memory_core;
	import hopf_pkg::*;

	localparam int WATCHDOG_LIMIT = 400000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [1:0]                 opcode = OP_CLEAR;
	logic [PAT_W-1:0]           pattern_bits = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [PAT_W-1:0]           result_pattern;
	logic signed [ENERGY_W-1:0] energy_value;
	logic [CNT_W-1:0]           stored_count;
	logic                       status;
	logic                       cfg_we = 1'b0;
	logic [SWEEP_W-1:0]         cfg_wdata = '0;
	int                         fail_count;
	int                         pending;
	int                         idle_cycles = 0;
	int                         stall_left = 0;

	// library of stored memories so recalls start near an attractor
	logic [PAT_W-1:0] memories [$];

	always #5 clk = ~clk;

	hopfield_associative_memory_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .pattern_bits(pattern_bits),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_pattern(result_pattern), .energy_value(energy_value),
		.stored_count(stored_count), .status(status),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	hopf_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .pattern_bits(pattern_bits),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_pattern(result_pattern), .energy_value(energy_value),
		.stored_count(stored_count), .status(status),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	// mostly short gaps, now and then a long one, sometimes none at all
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	// receiver stalls in random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready  <= 1'b1;
				stall_left <= gap_len();
			end
		end
	end

	// watchdog: cycles without any accepted item on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// valid stays up after an accept until the next item or a gap takes over
	task automatic send_item(op_t op, logic [PAT_W-1:0] bits);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		pattern_bits <= bits;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [PAT_W-1:0] rand_pat();
		return {$urandom(), $urandom()};
	endfunction

	// flip a few random cells of a stored memory
	function automatic logic [PAT_W-1:0] noisy(logic [PAT_W-1:0] p, int flips);
		for (int k = 0; k < flips; k++)
			p[$urandom_range(0, PAT_W - 1)] ^= 1'b1;
		return p;
	endfunction

	// quiet the block before a register write; a recall may run many sweeps
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3 * NEURONS_DEF * 2 + 10) @(posedge clk);
	endtask

	task automatic write_sweeps(logic [SWEEP_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int n_items);
		logic [PAT_W-1:0] p;
		int               r;
		for (int k = 0; k < n_items; k++) begin
			r = $urandom_range(0, 99);
			if (r < 25 || memories.size() == 0) begin
				p = rand_pat();
				// keep the memory small so recalls converge in few sweeps
				if (memories.size() >= 6) begin
					send_item(OP_CLEAR, rand_pat());
					memories.delete();
				end
				memories.insert(memories.size(), p);
				send_item(OP_STORE, p);
			end else if (r < 70) begin
				p = memories[$urandom_range(0, memories.size() - 1)];
				send_item(OP_RECALL, noisy(p, $urandom_range(0, 12)));
			end else if (r < 88) begin
				p = ($urandom_range(0, 1)) ? memories[$urandom_range(0, memories.size() - 1)]
					: rand_pat();
				send_item(OP_ENERGY, p);
			end else if (r < 95) begin
				send_item(OP_RECALL, rand_pat());
			end else begin
				send_item(OP_CLEAR, rand_pat());
				memories.delete();
			end
		end
	endtask

	initial begin
		logic [PAT_W-1:0] p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty memory, extremes of the pattern, every opcode
		send_item(OP_RECALL, '0);                // all fields zero: ties give +1
		send_item(OP_ENERGY, '1);
		send_item(OP_STORE, '1);
		send_item(OP_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(OP_ENERGY, '1);
		send_item(OP_ENERGY, 64'h5555_5555_5555_5555);
		send_item(OP_RECALL, 64'hFFFF_FFFF_FFFF_FFF0);
		send_item(OP_RECALL, 64'hAAAA_AAAA_AAAA_AAAB);
		send_item(OP_CLEAR, '1);
		send_item(OP_ENERGY, 64'h1234_5678_9ABC_DEF0);

		// zero sweeps: recall hands back the query
		wait_idle();
		write_sweeps(8'd0);
		send_item(OP_STORE, 64'hF0F0_0F0F_F0F0_0F0F);
		send_item(OP_RECALL, 64'hF0F0_0F0F_F0F0_0F00);
		send_item(OP_RECALL, 64'h8000_0000_0000_0001);
		wait_idle();
		write_sweeps(8'd1);
		send_item(OP_RECALL, 64'hF0F0_0F0F_F0F0_0F00);
		send_item(OP_CLEAR, '0);

		// memory full: fill with one repeated pattern, then two refused stores
		wait_idle();
		write_sweeps(8'd2);
		p = rand_pat();
		for (int k = 0; k < MAX_PATTERNS_DEF; k++)
			send_item(OP_STORE, p);
		send_item(OP_STORE, ~p);
		send_item(OP_STORE, '0);
		send_item(OP_ENERGY, p);
		send_item(OP_RECALL, noisy(p, 20));
		send_item(OP_CLEAR, p);

		// random phases across several sweep limits, extremes included
		wait_idle();
		write_sweeps(8'd255);
		random_phase(100);
		wait_idle();
		write_sweeps(8'd3);
		random_phase(100);
		wait_idle();
		write_sweeps(8'd0);
		random_phase(50);
		wait_idle();
		write_sweeps(MAX_SWEEPS_RST);
		random_phase(100);

		wait_idle();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ hopfield_associative_memory_core.f @@
rtl/hopf_pkg.sv
rtl/hopf_ram.sv
rtl/hopf_field.sv
rtl/hopf_rowupd.sv
rtl/hopfield_associative_memory_core.sv
rtl/hopf_chk.sv
tb/hopf_checker.sv
tb/tb_hopfield_associative_memory_core.sv
